// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the RTL that checks itself.
// No dependencies; the bodies collapse to nothing when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, held off while reset is low.
`define ASSERT_IMPLIES(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
        else $error("assertion failed");
// Next-cycle implication, held off while reset is low.
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, pre, post)
`define ASSERT_NEXT(label, clk, rst_n, pre, post)
`endif
`endif

// ===== hdl/tre_pkg.sv =====
// Shared types and constants of the Targa RLE index encoder.
// No dependencies; imported by every module of the encoder but tre_ram.
package tre_pkg;

    localparam int RAW_BUFFER_DEPTH = 128;
    localparam int RAW_AW           = $clog2(RAW_BUFFER_DEPTH);

    localparam logic [7:0] RAW_LIMIT     = 8'd127;
    localparam logic [7:0] RUN_LIMIT     = 8'd128;
    localparam logic [7:0] REPEAT_BIAS   = 8'd127;
    localparam logic [7:0] SHORT_RUN_MAX = 8'd2;

    localparam int CMDQ_DEPTH = 4;
    localparam int CMDQ_PW    = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_CW    = $clog2(CMDQ_DEPTH + 1);

    // Work for the back end: repeat packet, keep a short run as literals,
    // or keep a short run and then flush all literals (end of image).
    typedef enum logic [1:0] {
        OP_NONE,
        OP_REPEAT,
        OP_KEEP,
        OP_KEEP_FLUSH
    } op_kind_t;

    typedef struct packed {
        op_kind_t   kind;
        logic [7:0] value;
        logic [7:0] len;
    } op_t;

    // Everything one pixel causes: at most two operations, in order.
    typedef struct packed {
        op_t op_a;
        op_t op_b;
    } item_cmd_t;

    // Byte or end-of-item token from the sequencer to the beat packer.
    typedef struct packed {
        logic       fin;
        logic       pend;
        logic [7:0] data;
    } tok_t;

endpackage

// ===== hdl/tre_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tre_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/tre_fifo.sv =====
// Short command queue between the classifier and the packet sequencer.
// Depends on tre_pkg for item_cmd_t and the queue depth.
module tre_fifo import tre_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push,
    input  item_cmd_t din,
    output logic      full,
    input  logic      pop,
    output logic      valid,
    output item_cmd_t dout
);

    item_cmd_t            mem_reg [CMDQ_DEPTH];
    logic [CMDQ_PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [CMDQ_PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CMDQ_CW-1:0]   count_reg, count_next;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + CMDQ_PW'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + CMDQ_PW'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + CMDQ_CW'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CMDQ_CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= din;
        end
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assign full  = (count_reg == CMDQ_CW'(CMDQ_DEPTH));
    assign valid = (count_reg != '0);
    assign dout  = mem_reg[rd_ptr_reg];

endmodule

// ===== hdl/tre_front.sv =====
// Front end: accepts pixels, tracks the current run and classifies each pixel
// into packet work for the back end. Depends on tre_pkg.
module tre_front import tre_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_pixel_index,
    input  logic       s_end_of_image,
    input  logic       q_full,
    output logic       q_push,
    output item_cmd_t  q_cmd
);

    localparam op_t OP_IDLE = '{kind: OP_NONE, value: 8'h00, len: 8'h00};

    logic       first_pixel_reg;
    logic [7:0] last_value_reg;
    logic [7:0] run_length_reg;
    logic [7:0] last_value_next, run_length_next;
    logic       first_pixel_next;
    logic [7:0] lv_step, rl_step;
    op_t        op_a, op_b;
    logic       accept;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;

    always_comb begin
        op_a    = OP_IDLE;
        op_b    = OP_IDLE;
        lv_step = last_value_reg;
        rl_step = run_length_reg;
        if (first_pixel_reg) begin
            lv_step = s_pixel_index;
            rl_step = 8'd1;
        end else if (s_pixel_index == last_value_reg) begin
            if (run_length_reg != RUN_LIMIT) begin
                rl_step = run_length_reg + 8'd1;
            end else begin
                // run is full: close it as a repeat packet, open a new one
                op_a    = '{kind: OP_REPEAT, value: last_value_reg, len: run_length_reg};
                rl_step = 8'd1;
            end
        end else begin
            op_a.kind  = (run_length_reg > SHORT_RUN_MAX) ? OP_REPEAT : OP_KEEP;
            op_a.value = last_value_reg;
            op_a.len   = run_length_reg;
            lv_step    = s_pixel_index;
            rl_step    = 8'd1;
        end

        last_value_next  = lv_step;
        run_length_next  = rl_step;
        first_pixel_next = 1'b0;
        if (s_end_of_image) begin
            op_b.kind        = (rl_step > SHORT_RUN_MAX) ? OP_REPEAT : OP_KEEP_FLUSH;
            op_b.value       = lv_step;
            op_b.len         = rl_step;
            last_value_next  = 8'h00;
            run_length_next  = 8'h00;
            first_pixel_next = 1'b1;
        end

        // keep the first slot occupied whenever there is any work
        if (op_a.kind == OP_NONE) begin
            q_cmd.op_a = op_b;
            q_cmd.op_b = OP_IDLE;
        end else begin
            q_cmd.op_a = op_a;
            q_cmd.op_b = op_b;
        end
        q_push = accept && (q_cmd.op_a.kind != OP_NONE);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_value_reg  <= 8'h00;
            run_length_reg  <= 8'h00;
            first_pixel_reg <= 1'b1;
        end else if (accept) begin
            last_value_reg  <= last_value_next;
            run_length_reg  <= run_length_next;
            first_pixel_reg <= first_pixel_next;
        end
    end

endmodule

// ===== hdl/tre_pack.sv =====
// Beat packer: gathers packet bytes into beats of BEAT_BYTES and drives the
// registered result channel. Depends on tre_pkg for tok_t.
module tre_pack import tre_pkg::*; #(
    parameter int BEAT_BYTES = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        tok_valid,
    input  tok_t        tok,
    output logic        tok_ready,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_beat_data,
    output logic [3:0]  m_beat_bytes,
    output logic        m_packet_end,
    output logic        m_last_beat
);

    localparam int SLOT_W = $clog2(BEAT_BYTES);
    localparam int CNT_W  = $clog2(BEAT_BYTES + 1);

    logic [7:0]        acc_reg [BEAT_BYTES];
    logic [7:0]        acc_next [BEAT_BYTES];
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              pend_reg, pend_next;
    logic              m_valid_reg, m_valid_next;
    logic [63:0]       m_data_reg, m_data_next;
    logic [3:0]        m_bytes_reg, m_bytes_next;
    logic              m_pend_reg, m_pend_next;
    logic              m_last_reg, m_last_next;

    logic              out_free, acc_full, acc_empty, need_emit, accept, emit;
    logic [SLOT_W-1:0] slot;
    logic [63:0]       beat_word;

    always_comb begin
        out_free  = !m_valid_reg || m_ready;
        acc_full  = (cnt_reg == CNT_W'(BEAT_BYTES));
        acc_empty = (cnt_reg == '0);
        // a full beat leaves only once the next byte or the end-of-item token shows whether it is the last
        need_emit = tok.fin ? !acc_empty : acc_full;
        tok_ready = need_emit ? out_free : 1'b1;
        accept    = tok_valid && tok_ready;
        emit      = accept && need_emit;
        slot      = acc_full ? '0 : cnt_reg[SLOT_W-1:0];

        beat_word = '0;
        for (int i = 0; i < BEAT_BYTES; i++) begin
            if (CNT_W'(i) < cnt_reg) begin
                beat_word[8*i +: 8] = acc_reg[i];
            end
        end

        for (int i = 0; i < BEAT_BYTES; i++) begin
            acc_next[i] = acc_reg[i];
            if (accept && !tok.fin && (SLOT_W'(i) == slot)) begin
                acc_next[i] = tok.data;
            end
        end

        cnt_next  = cnt_reg;
        pend_next = pend_reg;
        if (accept) begin
            if (tok.fin) begin
                cnt_next  = '0;
                pend_next = 1'b0;
            end else if (acc_full) begin
                cnt_next  = CNT_W'(1);
                pend_next = tok.pend;
            end else begin
                cnt_next  = cnt_reg + CNT_W'(1);
                pend_next = pend_reg || tok.pend;
            end
        end

        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        m_bytes_next = m_bytes_reg;
        m_pend_next  = m_pend_reg;
        m_last_next  = m_last_reg;
        if (emit) begin
            m_valid_next = 1'b1;
            m_data_next  = beat_word;
            m_bytes_next = 4'(cnt_reg);
            m_pend_next  = pend_reg;
            m_last_next  = tok.fin;
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg     <= acc_next;
        m_data_reg  <= m_data_next;
        m_bytes_reg <= m_bytes_next;
        m_pend_reg  <= m_pend_next;
        m_last_reg  <= m_last_next;
        if (!aresetn) begin
            cnt_reg     <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            cnt_reg     <= cnt_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_beat_data  = m_data_reg;
    assign m_beat_bytes = m_bytes_reg;
    assign m_packet_end = m_pend_reg;
    assign m_last_beat  = m_last_reg;

endmodule

// ===== hdl/tre_back.sv =====
// Back end: runs the queued packet work, owns the literal buffer RAM and
// streams packet bytes to the beat packer. Depends on tre_pkg and tre_ram.
module tre_back import tre_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      q_valid,
    input  item_cmd_t q_cmd,
    output logic      q_pop,
    output logic      tok_valid,
    output tok_t      tok,
    input  logic      tok_ready
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_OP_B,
        S_FL_HDR,
        S_FL_DATA,
        S_REP_HDR,
        S_REP_VAL,
        S_APPEND,
        S_FIN
    } state_t;

    // where to go once a literal flush is out
    typedef enum logic [1:0] {
        AFT_REPEAT,
        AFT_APPEND,
        AFT_DONE
    } aft_t;

    state_t              state_reg, state_next;
    aft_t                after_reg, after_next;
    op_t                 op_reg, op_next;
    op_t                 op_b_reg, op_b_next;
    logic                phase_b_reg, phase_b_next;
    logic [RAW_AW-1:0]   raw_count_reg, raw_count_next;
    logic [RAW_AW-1:0]   idx_reg, idx_next;
    logic [1:0]          app_left_reg, app_left_next;
    logic                have_bytes_reg, have_bytes_next;

    logic                b_pending, last_lit;
    logic                ram_wr_en;
    logic [RAW_AW-1:0]   ram_rd_addr;
    logic [7:0]          ram_rd_data;

    function automatic state_t entry_state(input op_t op, input logic [RAW_AW-1:0] rc);
        logic [7:0] fill;
        fill = {1'b0, rc} + op.len;
        unique case (op.kind)
            OP_REPEAT:               return (rc != '0) ? S_FL_HDR : S_REP_HDR;
            OP_KEEP, OP_KEEP_FLUSH:  return (fill > RAW_LIMIT) ? S_FL_HDR : S_APPEND;
            default:                 return S_IDLE;
        endcase
    endfunction

    function automatic aft_t entry_after(input op_t op);
        return (op.kind == OP_REPEAT) ? AFT_REPEAT : AFT_APPEND;
    endfunction

    tre_ram #(
        .WIDTH (8),
        .DEPTH (RAW_BUFFER_DEPTH)
    ) u_raw_buf (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (raw_count_reg),
        .wr_data (op_reg.value),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    always_comb begin
        state_next      = state_reg;
        after_next      = after_reg;
        op_next         = op_reg;
        op_b_next       = op_b_reg;
        phase_b_next    = phase_b_reg;
        raw_count_next  = raw_count_reg;
        idx_next        = idx_reg;
        app_left_next   = app_left_reg;
        have_bytes_next = have_bytes_reg;
        q_pop           = 1'b0;
        tok_valid       = 1'b0;
        tok             = '{fin: 1'b0, pend: 1'b0, data: 8'h00};
        ram_wr_en       = 1'b0;
        ram_rd_addr     = '0;
        b_pending       = !phase_b_reg && (op_b_reg.kind != OP_NONE);
        last_lit        = (idx_reg == raw_count_reg - RAW_AW'(1));

        unique case (state_reg)
            S_IDLE: begin
                if (q_valid) begin
                    q_pop           = 1'b1;
                    op_next         = q_cmd.op_a;
                    op_b_next       = q_cmd.op_b;
                    phase_b_next    = 1'b0;
                    have_bytes_next = 1'b0;
                    state_next      = entry_state(q_cmd.op_a, raw_count_reg);
                    after_next      = entry_after(q_cmd.op_a);
                    app_left_next   = q_cmd.op_a.len[1:0];
                end
            end
            S_OP_B: begin
                op_next       = op_b_reg;
                phase_b_next  = 1'b1;
                state_next    = entry_state(op_b_reg, raw_count_reg);
                after_next    = entry_after(op_b_reg);
                app_left_next = op_b_reg.len[1:0];
            end
            S_FL_HDR: begin
                tok_valid = 1'b1;
                tok.data  = {1'b0, raw_count_reg - RAW_AW'(1)};
                if (tok_ready) begin
                    idx_next        = '0;
                    have_bytes_next = 1'b1;
                    state_next      = S_FL_DATA;
                end
            end
            S_FL_DATA: begin
                tok_valid   = 1'b1;
                tok.data    = ram_rd_data;
                tok.pend    = last_lit;
                // advance the read address only when the current literal leaves
                ram_rd_addr = tok_ready ? idx_reg + RAW_AW'(1) : idx_reg;
                if (tok_ready) begin
                    idx_next = idx_reg + RAW_AW'(1);
                    if (last_lit) begin
                        raw_count_next = '0;
                        unique case (after_reg)
                            AFT_REPEAT: state_next = S_REP_HDR;
                            AFT_APPEND: state_next = S_APPEND;
                            default:    state_next = b_pending ? S_OP_B : S_FIN;
                        endcase
                    end
                end
            end
            S_REP_HDR: begin
                tok_valid = 1'b1;
                tok.data  = op_reg.len + REPEAT_BIAS;
                if (tok_ready) begin
                    have_bytes_next = 1'b1;
                    state_next      = S_REP_VAL;
                end
            end
            S_REP_VAL: begin
                tok_valid = 1'b1;
                tok.data  = op_reg.value;
                tok.pend  = 1'b1;
                if (tok_ready) begin
                    state_next = b_pending ? S_OP_B : S_FIN;
                end
            end
            S_APPEND: begin
                ram_wr_en      = 1'b1;
                raw_count_next = raw_count_reg + RAW_AW'(1);
                app_left_next  = app_left_reg - 2'd1;
                if (app_left_reg == 2'd1) begin
                    if (op_reg.kind == OP_KEEP_FLUSH) begin
                        after_next = AFT_DONE;
                        state_next = S_FL_HDR;
                    end else if (b_pending) begin
                        state_next = S_OP_B;
                    end else begin
                        state_next = have_bytes_reg ? S_FIN : S_IDLE;
                    end
                end
            end
            S_FIN: begin
                tok_valid = 1'b1;
                tok.fin   = 1'b1;
                if (tok_ready) begin
                    have_bytes_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        op_reg       <= op_next;
        op_b_reg     <= op_b_next;
        idx_reg      <= idx_next;
        app_left_reg <= app_left_next;
        after_reg    <= after_next;
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            phase_b_reg    <= 1'b0;
            raw_count_reg  <= '0;
            have_bytes_reg <= 1'b0;
        end else begin
            state_reg      <= state_next;
            phase_b_reg    <= phase_b_next;
            raw_count_reg  <= raw_count_next;
            have_bytes_reg <= have_bytes_next;
        end
    end

endmodule

// ===== hdl/tga_rle_index_encoder_top.sv =====
// Top level of the Targa type-9 RLE encoder for 8-bit color-map indices.
// Depends on tre_pkg, tre_front, tre_fifo, tre_back, tre_pack, assert_macros.svh.
//
//  channel  | handshake         | payload
//  ---------+-------------------+---------------------------------------------
//  s_ (in)  | s_valid / s_ready | s_pixel_index[7:0], s_end_of_image
//  m_ (out) | m_valid / m_ready | m_beat_data[63:0], m_beat_bytes[3:0],
//           |                   | m_packet_end, m_last_beat
//
// Cycles: the front takes one pixel per cycle while the command queue has room;
//   a pixel that only lengthens a run costs nothing further. In the back, a
//   short run is dispatched, then written to the buffer one literal at a time; a
//   repeat packet sends a header and a value, and a raw flush a header and then
//   one literal per cycle while the packer accepts, through the single read port of the literal buffer.
// Reset: aresetn is synchronous, active low; the literal buffer is not cleared.
// Stalls: m_ready low first fills the output beat register, then the packer,
//   then the sequencer, then the four-entry queue, and only then drops s_ready.
`include "assert_macros.svh"

module tga_rle_index_encoder_top import tre_pkg::*; #(
    parameter int BEAT_BYTES = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    // pixel input
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_pixel_index,
    input  logic        s_end_of_image,
    // packet beats
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_beat_data,
    output logic [3:0]  m_beat_bytes,
    output logic        m_packet_end,
    output logic        m_last_beat
);

    // front -> queue
    logic      q_push;
    logic      q_full;
    item_cmd_t q_din;

    // queue -> back
    logic      q_valid;
    logic      q_pop;
    item_cmd_t q_dout;

    // back -> packer byte stream
    logic      tok_valid;
    logic      tok_ready;
    tok_t      tok;

    // Classify each pixel against the current run; push work only when a
    // packet or a literal append is due.
    tre_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_pixel_index  (s_pixel_index),
        .s_end_of_image (s_end_of_image),
        .q_full         (q_full),
        .q_push         (q_push),
        .q_cmd          (q_din)
    );

    // Hold pending work so the front keeps taking pixels during long flushes.
    tre_fifo u_cmdq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .din     (q_din),
        .full    (q_full),
        .pop     (q_pop),
        .valid   (q_valid),
        .dout    (q_dout)
    );

    // Sequence raw and repeat packets byte by byte; owns the literal buffer.
    tre_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (q_valid),
        .q_cmd     (q_dout),
        .q_pop     (q_pop),
        .tok_valid (tok_valid),
        .tok       (tok),
        .tok_ready (tok_ready)
    );

    // Gather bytes into beats; a full beat waits for the next byte or the
    // end-of-item token so the last beat of an item is flagged correctly.
    tre_pack #(
        .BEAT_BYTES (BEAT_BYTES)
    ) u_pack (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .tok_valid    (tok_valid),
        .tok          (tok),
        .tok_ready    (tok_ready),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_beat_data  (m_beat_data),
        .m_beat_bytes (m_beat_bytes),
        .m_packet_end (m_packet_end),
        .m_last_beat  (m_last_beat)
    );

    // The front never pushes into a full queue.
    `ASSERT_IMPLIES(a_push_room, aclk, aresetn, q_push, !q_full)
    // A pushed command is visible to the back on the next cycle.
    `ASSERT_NEXT(a_push_seen, aclk, aresetn, q_push, q_valid)
    // Only the final beat of an item may be short.
    `ASSERT_IMPLIES(a_full_beats, aclk, aresetn, m_valid && !m_last_beat, m_beat_bytes == 4'(BEAT_BYTES))
    // Every beat carries at least one and at most BEAT_BYTES bytes.
    `ASSERT_IMPLIES(a_beat_size, aclk, aresetn, m_valid, (m_beat_bytes != 4'd0) && (m_beat_bytes <= 4'(BEAT_BYTES)))

endmodule
